[sv/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants of the pulse-skip modulator
// Holds the item, configuration and state types used by the core and its
// single-pass update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 31;

  localparam logic [15:0] RangeReset     = 16'd127;
  localparam logic [7:0]  DividerReset   = 8'd1;
  localparam logic [7:0]  MinGapReset    = 8'd0;
  localparam logic [30:0] StopAfterReset = 31'd0;
  localparam logic [15:0] PowerReset     = 16'd10;

  typedef enum logic [1:0] {
    KindCross    = 2'd0,
    KindTimer    = 2'd1,
    KindSetPoint = 2'd2,
    KindClear    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRange     = 2'd0,
    CfgDivider   = 2'd1,
    CfgMinGap    = 2'd2,
    CfgStopAfter = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] range;
    logic [7:0]  divider;
    logic [7:0]  min_gap_ms;
    logic [30:0] stop_after;
  } cfg_t;

  typedef struct packed {
    logic [15:0] accumulator;
    logic        skip_flag;
    logic [7:0]  divide_count;
    logic [31:0] pulses;
    logic [31:0] last_cross_ms;
    logic [15:0] power_value;
    logic        drive_level;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [15:0] set_point;
  } in_t;

  typedef struct packed {
    logic        drive;
    logic        timer_restart;
    logic        ignored;
    logic [31:0] pulse_count;
  } out_t;

endpackage

`default_nettype wire

[sv/psm_in_if.sv]
// ----------------------------------------------------------------------------
// psm_in_if: event channel of the pulse-skip modulator
// Valid/ready channel carrying one event item.
// ----------------------------------------------------------------------------
`default_nettype none

interface psm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [15:0] set_point;

  modport source (output valid, output kind, output now_ms, output set_point, input ready);
  modport sink   (input valid, input kind, input now_ms, input set_point, output ready);
endinterface

`default_nettype wire

[sv/psm_out_if.sv]
// ----------------------------------------------------------------------------
// psm_out_if: result channel of the pulse-skip modulator
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface psm_out_if;
  logic        valid;
  logic        ready;
  logic        drive;
  logic        timer_restart;
  logic        ignored;
  logic [31:0] pulse_count;

  modport source (output valid, output drive, output timer_restart, output ignored,
                  output pulse_count, input ready);
  modport sink   (input valid, input drive, input timer_restart, input ignored,
                  input pulse_count, output ready);
endinterface

`default_nettype wire

[sv/pulse_skip_modulator_core.sv]
// ----------------------------------------------------------------------------
// pulse_skip_modulator_core: mains pulse-skip modulator for one output line
// Event items in, one result item out per event.
// ----------------------------------------------------------------------------
// Usage: every event item yields exactly one result item, and one item is
// accepted per cycle while input ready is high: an input register feeds a
// single combinational update (a 17-bit accumulator add, fold and compare plus
// a 32-bit counter increment and limit compare), whose result lands in the
// output register. Input ready drops only while the output register holds an
// unread item and the input register is also full. The user must write the
// configuration registers (range, divider, min_gap_ms, stop_after) through
// cfg_we_i / cfg_idx_i / cfg_wdata_i only while no item is in flight; the core does not enforce it.
`default_nettype none

module pulse_skip_modulator_core (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [psm_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  wire [psm_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  psm_in_if.sink                               in_if,
  psm_out_if.source                            out_if
);
  import psm_pkg::*;

  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;
  in_t    item_q;
  logic   item_valid_q;
  out_t   result_d;
  out_t   result_q;
  logic   out_valid_q;
  logic   advance;
  logic   accept;

  assign advance      = item_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !item_valid_q || advance;
  assign accept       = in_if.valid && in_if.ready;

  psm_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range      <= RangeReset;
      cfg_q.divider    <= DividerReset;
      cfg_q.min_gap_ms <= MinGapReset;
      cfg_q.stop_after <= StopAfterReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRange:     cfg_q.range      <= cfg_wdata_i[15:0];
        CfgDivider:   cfg_q.divider    <= cfg_wdata_i[7:0];
        CfgMinGap:    cfg_q.min_gap_ms <= cfg_wdata_i[7:0];
        CfgStopAfter: cfg_q.stop_after <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.accumulator   <= 16'd0;
      state_q.skip_flag     <= 1'b0;
      state_q.divide_count  <= 8'd0;
      state_q.pulses        <= 32'd0;
      state_q.last_cross_ms <= 32'd0;
      state_q.power_value   <= PowerReset;
      state_q.drive_level   <= 1'b0;
      item_valid_q          <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (accept) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind      <= in_if.kind;
      item_q.now_ms    <= in_if.now_ms;
      item_q.set_point <= in_if.set_point;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.drive         = result_q.drive;
  assign out_if.timer_restart = result_q.timer_restart;
  assign out_if.ignored       = result_q.ignored;
  assign out_if.pulse_count   = result_q.pulse_count;

endmodule

`default_nettype wire

[sv/psm_step.sv]
// ----------------------------------------------------------------------------
// psm_step: one event applied to the modulator state
// Gap filter, divider, first-order accumulator, pulse counter and stop limit,
// all as one combinational pass from current state to next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_step (
  input  psm_pkg::cfg_t   cfg_i,
  input  psm_pkg::state_t state_i,
  input  psm_pkg::in_t    item_i,
  output psm_pkg::state_t state_o,
  output psm_pkg::out_t   result_o
);
  import psm_pkg::*;

  logic [31:0] gap;
  logic        ignore;
  logic [7:0]  step;
  logic        update;
  logic [16:0] sum;
  logic [16:0] diff;
  logic [16:0] folded;
  logic        ge;
  logic        over;
  logic        conduct;
  logic [15:0] acc_new;
  logic [31:0] pulses_inc;
  logic        blocked;
  state_t      st;
  logic        restart;

  assign gap    = item_i.now_ms - state_i.last_cross_ms;
  assign ignore = (cfg_i.min_gap_ms != 8'd0) && (gap < {24'd0, cfg_i.min_gap_ms});
  // divider of zero behaves as one
  assign step   = (cfg_i.divider == 8'd0) ? 8'd0 : cfg_i.divider - 8'd1;
  assign update = state_i.divide_count >= step;

  assign sum     = {1'b0, state_i.accumulator} + {1'b0, state_i.power_value};
  assign ge      = sum >= {1'b0, cfg_i.range};
  assign diff    = sum - {1'b0, cfg_i.range};
  assign folded  = ge ? diff : sum;
  // stale power value above a lowered range: clear and conduct
  assign over    = folded > {1'b0, cfg_i.range};
  assign conduct = ge;
  assign acc_new = over ? 16'd0 : folded[15:0];

  assign pulses_inc = state_i.pulses + {31'd0, conduct};
  assign blocked    = conduct && (cfg_i.stop_after != 31'd0) &&
                      (pulses_inc > {1'b0, cfg_i.stop_after});

  always_comb begin
    st      = state_i;
    restart = 1'b0;
    case (kind_e'(item_i.kind))
      KindCross: begin
        if (!ignore) begin
          st.last_cross_ms = item_i.now_ms;
          if (update) begin
            st.divide_count = state_i.divide_count - step;
            st.accumulator  = acc_new;
            st.skip_flag    = !conduct || blocked;
            st.pulses       = pulses_inc;
          end else begin
            st.divide_count = state_i.divide_count + 8'd1;
          end
          st.drive_level = !st.skip_flag;
          restart        = 1'b1;
        end
      end
      KindTimer: begin
        st.drive_level = 1'b0;
      end
      KindSetPoint: begin
        st.power_value = (item_i.set_point < cfg_i.range) ? item_i.set_point : cfg_i.range;
      end
      KindClear: begin
        st.pulses = 32'd0;
      end
      default: begin
      end
    endcase
  end

  assign state_o                = st;
  assign result_o.drive         = st.drive_level;
  assign result_o.timer_restart = restart;
  assign result_o.ignored       = (kind_e'(item_i.kind) == KindCross) && ignore;
  assign result_o.pulse_count   = st.pulses;

endmodule

`default_nettype wire

[sv/psm_checker.sv]
// ----------------------------------------------------------------------------
// psm_checker: port-level checks of the pulse-skip modulator
// Watches the event and result channels of the core; bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire        out_drive_i,
  input wire        out_timer_restart_i,
  input wire        out_ignored_i,
  input wire [31:0] out_pulse_count_i
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_drive_i) &&
      $stable(out_timer_restart_i) && $stable(out_ignored_i) && $stable(out_pulse_count_i))
    else $error("result item changed while stalled");

  // a rejected cross never restarts the timer
  a_ign_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_ignored_i && out_timer_restart_i))
    else $error("ignored and timer_restart both set");

  // input only stalls behind a full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with free output");

  // a newly valid result traces back to an accepted item through the input and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result item without a matching accepted item");

endmodule

bind pulse_skip_modulator_core psm_checker u_psm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_if.valid),
  .in_ready_i          (in_if.ready),
  .out_valid_i         (out_if.valid),
  .out_ready_i         (out_if.ready),
  .out_drive_i         (out_if.drive),
  .out_timer_restart_i (out_if.timer_restart),
  .out_ignored_i       (out_if.ignored),
  .out_pulse_count_i   (out_if.pulse_count)
);

`default_nettype wire
